@@ sv/lru_pkg.sv @@
// constants and types for the lru page replacement stack
// no dependencies
package lru_pkg;

    localparam int MAX_FRAMES     = 8;
    localparam int PAGE_BITS      = 16;
    localparam int COUNT_BITS     = 32;
    localparam int FRAME_CFG_BITS = 4;
    localparam int IDX_BITS       = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

    localparam logic [FRAME_CFG_BITS-1:0] FRAMES_RESET = FRAME_CFG_BITS'(8);

    typedef logic [PAGE_BITS-1:0]      page_t;
    typedef logic [COUNT_BITS-1:0]     count_t;
    typedef logic [IDX_BITS-1:0]       idx_t;
    typedef logic [FRAME_CFG_BITS-1:0] frame_cfg_t;

endpackage

@@ sv/lru_page_replacement_stack.sv @@
// lru page replacement recency stack, top level
// depends on lru_pkg
// Each accepted page reference scans n stack entries, n = 1..8 being the number of
// entries checked before the first match or the end of the active region: a single
// comparator visits one stack entry per cycle, then the update state moves the stack and
// updates the counts. The update state also waits for the output register to be free,
// so a stalled result holds it there. Input stall is high from the cycle after a
// transfer until that update is done. The frame count register can be written
// at any time the block is idle and is always ready.
module lru_page_replacement_stack (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  lru_pkg::frame_cfg_t          frames_in_use,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  lru_pkg::page_t               page_number,
    input  logic                         last_ref,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         hit,
    output lru_pkg::count_t              hit_count,
    output lru_pkg::count_t              miss_count,
    output logic                         run_done
);
    import lru_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;

    logic [1:0]       state_reg, state_next;
    frame_cfg_t       frames_reg;
    page_t            pages_reg [MAX_FRAMES];
    logic [MAX_FRAMES-1:0] valid_reg;
    count_t           hits_reg, misses_reg;
    page_t            page_reg;
    logic             last_reg;
    logic             hit_reg;
    idx_t             idx_reg, idx_next;
    idx_t             top_reg, top_next;
    idx_t             limit_reg;
    idx_t             limit_cfg;
    logic             match;
    logic             upd_fire;
    logic             out_valid_reg;
    logic             res_hit_reg;
    count_t           res_hits_reg, res_misses_reg;
    logic             res_done_reg;
    count_t           hits_next, misses_next;

    function automatic logic frames_in_use_zero(input frame_cfg_t f);
        return (f == '0);
    endfunction

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);

    // last index of the active region
    always_comb
    begin
        if (frames_in_use_zero(frames_reg))
            limit_cfg = '0;
        else if (32'(frames_reg) > MAX_FRAMES)
            limit_cfg = IDX_BITS'(MAX_FRAMES - 1);
        else
            limit_cfg = IDX_BITS'(frames_reg - 1'b1);
    end

    // shared comparator
    assign match = valid_reg[idx_reg] && (pages_reg[idx_reg] == page_reg);

    assign upd_fire = (state_reg == ST_UPDATE) && (!out_valid_reg || !out_stall);

    assign hits_next   = (hit_reg && hits_reg != '1) ? hits_reg + 1'b1 : hits_reg;
    assign misses_next = (!hit_reg && misses_reg != '1) ? misses_reg + 1'b1 : misses_reg;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        top_next   = top_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                    idx_next   = '0;
                end
            end
            ST_SCAN:
            begin
                if (match || idx_reg == limit_reg)
                begin
                    state_next = ST_UPDATE;
                    top_next   = idx_reg;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_UPDATE:
            begin
                if (upd_fire)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            frames_reg    <= FRAMES_RESET;
            valid_reg     <= '0;
            hits_reg      <= '0;
            misses_reg    <= '0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            top_reg       <= '0;
            hit_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            top_reg   <= top_next;
            if (cfg_valid && cfg_ready)
                frames_reg <= frames_in_use;
            if (state_reg == ST_IDLE && in_valid)
                hit_reg <= 1'b0;
            else if (state_reg == ST_SCAN)
                hit_reg <= match;
            if (upd_fire)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            if (upd_fire)
            begin
                if (last_reg)
                begin
                    valid_reg  <= '0;
                    hits_reg   <= '0;
                    misses_reg <= '0;
                end
                else
                begin
                    for (int k = 1; k < MAX_FRAMES; k++)
                    begin
                        if (32'(top_reg) >= k)
                            valid_reg[k] <= valid_reg[k-1];
                    end
                    valid_reg[0] <= 1'b1;
                    hits_reg     <= hits_next;
                    misses_reg   <= misses_next;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            page_reg  <= page_number;
            last_reg  <= last_ref;
            limit_reg <= limit_cfg;
        end
        if (upd_fire)
        begin
            res_hit_reg    <= hit_reg;
            res_hits_reg   <= hits_next;
            res_misses_reg <= misses_next;
            res_done_reg   <= last_reg;
            for (int k = 1; k < MAX_FRAMES; k++)
            begin
                if (32'(top_reg) >= k)
                    pages_reg[k] <= pages_reg[k-1];
            end
            pages_reg[0] <= page_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign hit        = res_hit_reg;
    assign hit_count  = res_hits_reg;
    assign miss_count = res_misses_reg;
    assign run_done   = res_done_reg;

    a_scan_in_region: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (idx_reg <= limit_reg))
        else $error("scan index past active region");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        upd_fire |=> out_valid_reg && (res_done_reg == $past(last_reg)))
        else $error("result not loaded on update");

    a_run_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (upd_fire && last_reg) |=> (valid_reg == '0) && (hits_reg == '0) && (misses_reg == '0))
        else $error("stack or counts not cleared after last reference");

    a_front_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (upd_fire && !last_reg) |=> valid_reg[0] && (pages_reg[0] == $past(page_reg)))
        else $error("referenced page not at most-recent end");

    a_hit_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_hit_reg) |-> (res_hits_reg != '0))
        else $error("hit reported with zero hit count");

endmodule
